@@ hw/rtl/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int DATA_W = 16;
	localparam int FRAC_W = DATA_W - 2;
	localparam int THR_W  = 15;
	localparam int P_W    = 18;
	localparam int MAG_W  = 17;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int ROOT_W = SUM_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int NUM_W  = MAG_W + FRAC_W + 1;
	localparam int Q_W    = FRAC_W + 1;

	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	localparam logic signed [P_W-1:0] ONE_P = P_W'(1 << FRAC_W);

	typedef struct packed {
		logic [3:0][MAG_W-1:0] mag;
		logic [3:0]            neg;
		logic [1:0]            branch;
	} rmq_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rmq_fifo_stat_t;

endpackage

@@ hw/rtl/rmq_front.sv @@
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix, picks the branch and forms the unscaled quaternion.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     cfg_we,
	input  logic [THR_W-1:0]         cfg_wdata,
	input  logic signed [DATA_W-1:0] e00,
	input  logic signed [DATA_W-1:0] e01,
	input  logic signed [DATA_W-1:0] e02,
	input  logic signed [DATA_W-1:0] e10,
	input  logic signed [DATA_W-1:0] e11,
	input  logic signed [DATA_W-1:0] e12,
	input  logic signed [DATA_W-1:0] e20,
	input  logic signed [DATA_W-1:0] e21,
	input  logic signed [DATA_W-1:0] e22,
	input  rmq_fifo_stat_t           fstat,
	output logic                     push,
	output rmq_item_t                push_item
);

	logic [THR_W-1:0] thr_q;
	logic             valid_s1;
	rmq_item_t        item_s1;

	logic signed [P_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, thr_p;
	logic signed [P_W-1:0] t0, t1, t2, t3;
	logic signed [P_W-1:0] p [4];
	logic signed [P_W-1:0] pn;
	rmq_item_t             item_d;
	logic                  accept;

	always_comb begin
		a00 = P_W'(e00); a01 = P_W'(e01); a02 = P_W'(e02);
		a10 = P_W'(e10); a11 = P_W'(e11); a12 = P_W'(e12);
		a20 = P_W'(e20); a21 = P_W'(e21); a22 = P_W'(e22);
		thr_p = $signed({{(P_W-THR_W){1'b0}}, thr_q});
		t0 = ONE_P + a00 + a11 + a22;
		t1 = ONE_P + a00 - a11 - a22;
		t2 = ONE_P - a00 + a11 - a22;
		t3 = ONE_P - a00 - a11 + a22;
		if (t0 >= thr_p) begin
			item_d.branch = BR_TRACE;
			p[3] = t0; p[0] = a21 - a12; p[1] = a02 - a20; p[2] = a10 - a01;
		end else if (t1 >= thr_p) begin
			item_d.branch = BR_X;
			p[0] = t1; p[1] = a10 + a01; p[2] = a02 + a20; p[3] = a21 - a12;
		end else if (t2 >= thr_p) begin
			item_d.branch = BR_Y;
			p[1] = t2; p[0] = a10 + a01; p[2] = a21 + a12; p[3] = a02 - a20;
		end else begin
			item_d.branch = BR_Z;
			p[2] = t3[P_W-1] ? '0 : t3;
			p[0] = a02 + a20; p[1] = a21 + a12; p[3] = a10 - a01;
		end
		for (int i = 0; i < 4; i++) begin
			pn = -p[i];
			item_d.neg[i] = p[i][P_W-1];
			item_d.mag[i] = p[i][P_W-1] ? pn[MAG_W-1:0] : p[i][MAG_W-1:0];
		end
	end

	assign busy      = valid_s1 & fstat.full;
	assign accept    = start & ~busy;
	assign push      = valid_s1 & ~fstat.full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_W'(1);
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (!busy) begin
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ hw/rtl/rmq_fifo.sv @@
// ----------------------------------------------------------------------------
// rmq_fifo
// Two-entry item queue between front and back.
// ----------------------------------------------------------------------------
module rmq_fifo import rmq_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rmq_item_t      push_item,
	input  logic           pop,
	output rmq_item_t      pop_item,
	output rmq_fifo_stat_t fstat
);

	rmq_item_t  mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign fstat.full  = (cnt_q == 2'd2);
	assign fstat.empty = (cnt_q == 2'd0);
	assign pop_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && fstat.full))
		else $error("item pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && fstat.empty))
		else $error("item popped from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");
`endif

endmodule

@@ hw/rtl/rmq_back.sv @@
// ----------------------------------------------------------------------------
// rmq_back
// Squares, pipelined square root, four pipelined dividers and output stage.
// ----------------------------------------------------------------------------
module rmq_back import rmq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rmq_fifo_stat_t           fstat,
	input  rmq_item_t                pop_item,
	output logic                     pop,
	output logic                     done,
	output logic signed [DATA_W-1:0] quat_x,
	output logic signed [DATA_W-1:0] quat_y,
	output logic signed [DATA_W-1:0] quat_z,
	output logic signed [DATA_W-1:0] quat_w,
	output logic [1:0]               branch_taken
);

	typedef struct packed {
		logic [SUM_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		rmq_item_t         item;
	} sqrt_t;

	typedef struct packed {
		logic [3:0][ROOT_W-1:0] rem;
		logic [3:0][Q_W-1:0]    low;
		logic [3:0][Q_W-1:0]    quo;
		logic [ROOT_W-1:0]      norm;
		rmq_item_t              item;
	} div_t;

	logic                   valid_s1;
	rmq_item_t              item_s1;
	logic [3:0][SQ_W-1:0]   sq_s1;

	logic  sq_vld_s [ROOT_W+1];
	sqrt_t sq_s     [ROOT_W+1];
	logic  dv_vld_s [Q_W+1];
	div_t  dv_s     [Q_W+1];

	logic                     done_q;
	logic signed [DATA_W-1:0] qx_q, qy_q, qz_q, qw_q;
	logic [1:0]               br_q;

	assign pop = ~fstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			sq_vld_s[0] <= 1'b0;
		end else begin
			valid_s1    <= pop;
			sq_vld_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= pop_item;
		for (int i = 0; i < 4; i++) begin
			sq_s1[i] <= pop_item.mag[i] * pop_item.mag[i];
		end
		sq_s[0].rad  <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1])
			+ SUM_W'(sq_s1[2]) + SUM_W'(sq_s1[3]);
		sq_s[0].rem  <= '0;
		sq_s[0].root <= '0;
		sq_s[0].item <= item_s1;
	end

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
		logic [REM_W+1:0] rem2, trial;
		always_comb begin
			rem2  = {sq_s[k-1].rem, sq_s[k-1].rad[SUM_W-1 -: 2]};
			trial = {2'b00, sq_s[k-1].root, 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k] <= 1'b0;
			end else begin
				sq_vld_s[k] <= sq_vld_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			sq_s[k].rad  <= {sq_s[k-1].rad[SUM_W-3:0], 2'b00};
			sq_s[k].item <= sq_s[k-1].item;
			if (rem2 >= trial) begin
				sq_s[k].rem  <= REM_W'(rem2 - trial);
				sq_s[k].root <= {sq_s[k-1].root[ROOT_W-2:0], 1'b1};
			end else begin
				sq_s[k].rem  <= REM_W'(rem2);
				sq_s[k].root <= {sq_s[k-1].root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= sq_vld_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		logic [NUM_W-1:0] num;
		for (int i = 0; i < 4; i++) begin
			num = {sq_s[ROOT_W].item.mag[i], {FRAC_W{1'b0}}}
				+ NUM_W'(sq_s[ROOT_W].root >> 1);
			dv_s[0].rem[i] <= ROOT_W'(num[NUM_W-1:Q_W]);
			dv_s[0].low[i] <= num[Q_W-1:0];
			dv_s[0].quo[i] <= '0;
		end
		dv_s[0].norm <= sq_s[ROOT_W].root;
		dv_s[0].item <= sq_s[ROOT_W].item;
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else begin
				dv_vld_s[k] <= dv_vld_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			logic [ROOT_W:0] r2;
			for (int i = 0; i < 4; i++) begin
				r2 = {dv_s[k-1].rem[i], dv_s[k-1].low[i][Q_W-1]};
				dv_s[k].low[i] <= {dv_s[k-1].low[i][Q_W-2:0], 1'b0};
				if (r2 >= {1'b0, dv_s[k-1].norm}) begin
					dv_s[k].rem[i] <= ROOT_W'(r2 - {1'b0, dv_s[k-1].norm});
					dv_s[k].quo[i] <= {dv_s[k-1].quo[i][Q_W-2:0], 1'b1};
				end else begin
					dv_s[k].rem[i] <= ROOT_W'(r2);
					dv_s[k].quo[i] <= {dv_s[k-1].quo[i][Q_W-2:0], 1'b0};
				end
			end
			dv_s[k].norm <= dv_s[k-1].norm;
			dv_s[k].item <= dv_s[k-1].item;
		end
	end

	logic signed [DATA_W-1:0] res [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			res[i] = dv_s[Q_W].item.neg[i] ? -$signed({1'b0, dv_s[Q_W].quo[i]})
				: $signed({1'b0, dv_s[Q_W].quo[i]});
		end
		if (dv_s[Q_W].norm == '0) begin
			res[0] = '0;
			res[1] = '0;
			res[2] = '0;
			res[3] = DATA_W'(1 << FRAC_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		qx_q <= res[0];
		qy_q <= res[1];
		qz_q <= res[2];
		qw_q <= res[3];
		br_q <= dv_s[Q_W].item.branch;
	end

	assign done         = done_q;
	assign quat_x       = qx_q;
	assign quat_y       = qy_q;
	assign quat_z       = qz_q;
	assign quat_w       = qw_q;
	assign branch_taken = br_q;

`ifndef NO_ASSERTIONS
	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && br_q == BR_TRACE) |-> !qw_q[DATA_W-1])
		else $error("trace branch gave negative w");
	a_x_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && br_q == BR_X) |-> !qx_q[DATA_W-1])
		else $error("x branch gave negative x");
	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> sq_vld_s[0])
		else $error("item lost after squaring stage");
`endif

endmodule

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd rotation matrix to unit quaternion conversion, Q2.14 fixed point.
// ----------------------------------------------------------------------------
// Takes one matrix per clock while busy is low and returns each quaternion
// with a one-cycle done strobe after the 18-stage square root of the
// squared norm and the 15-stage dividers, one per component. Results
// cannot be held off; a two-entry queue separates branch selection from
// the arithmetic pipeline.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     cfg_we,
	input  logic [THR_W-1:0]         cfg_wdata,
	input  logic signed [DATA_W-1:0] e00,
	input  logic signed [DATA_W-1:0] e01,
	input  logic signed [DATA_W-1:0] e02,
	input  logic signed [DATA_W-1:0] e10,
	input  logic signed [DATA_W-1:0] e11,
	input  logic signed [DATA_W-1:0] e12,
	input  logic signed [DATA_W-1:0] e20,
	input  logic signed [DATA_W-1:0] e21,
	input  logic signed [DATA_W-1:0] e22,
	output logic                     done,
	output logic signed [DATA_W-1:0] quat_x,
	output logic signed [DATA_W-1:0] quat_y,
	output logic signed [DATA_W-1:0] quat_z,
	output logic signed [DATA_W-1:0] quat_w,
	output logic [1:0]               branch_taken
);

	rmq_fifo_stat_t fstat;
	logic           push, pop;
	rmq_item_t      push_item, pop_item;

	rmq_front u_front (
		.clk, .arst_n, .start, .busy, .cfg_we, .cfg_wdata,
		.e00, .e01, .e02, .e10, .e11, .e12, .e20, .e21, .e22,
		.fstat, .push, .push_item
	);

	rmq_fifo u_fifo (
		.clk, .arst_n, .push, .push_item, .pop, .pop_item, .fstat
	);

	rmq_back u_back (
		.clk, .arst_n, .fstat, .pop_item, .pop, .done,
		.quat_x, .quat_y, .quat_z, .quat_w, .branch_taken
	);

endmodule

@@ test/rotation_matrix_to_quaternion_test.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Drives matrices into the Shepperd quaternion block and checks every
// quaternion against an exact integer predictor, over several thresholds.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
	import rmq_pkg::*;

	typedef struct {
		logic signed [DATA_W-1:0] e [9];
	} matrix_t;

	typedef struct {
		logic signed [DATA_W-1:0] x, y, z, w;
		logic [1:0]               branch;
	} quat_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     cfg_we;
	logic [THR_W-1:0]         cfg_wdata;
	logic signed [DATA_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic                     done;
	logic signed [DATA_W-1:0] quat_x, quat_y, quat_z, quat_w;
	logic [1:0]               branch_taken;

	matrix_t          pending_items[$];
	quat_t            expected_quats[$];
	logic [THR_W-1:0] threshold;
	int               errors;
	bit               calm;
	logic             busy_at_edge;

	rotation_matrix_to_quaternion u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.e00(e00), .e01(e01), .e02(e02), .e10(e10), .e11(e11), .e12(e12),
		.e20(e20), .e21(e21), .e22(e22),
		.done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.quat_w(quat_w), .branch_taken(branch_taken)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic logic signed [DATA_W-1:0] clip(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return DATA_W'(v);
	endfunction

	function automatic quat_t shepperd(matrix_t m, logic [THR_W-1:0] thr);
		longint          a [9];
		longint          p [4];
		longint          one, t0, t1, t2, t3, s;
		longint unsigned mag [4];
		longint unsigned sum, norm, r;
		logic signed [DATA_W-1:0] q [4];
		quat_t res;
		one = 64'sd1 << FRAC_W;
		sum = 0;
		for (int i = 0; i < 9; i++)
			a[i] = m.e[i];
		t0 = one + a[0] + a[4] + a[8];
		t1 = one + a[0] - a[4] - a[8];
		t2 = one - a[0] + a[4] - a[8];
		t3 = one - a[0] - a[4] + a[8];
		if (t0 >= longint'(thr)) begin
			res.branch = BR_TRACE;
			p[3] = t0; p[0] = a[7] - a[5]; p[1] = a[2] - a[6]; p[2] = a[3] - a[1];
		end else if (t1 >= longint'(thr)) begin
			res.branch = BR_X;
			p[0] = t1; p[1] = a[3] + a[1]; p[2] = a[2] + a[6]; p[3] = a[7] - a[5];
		end else if (t2 >= longint'(thr)) begin
			res.branch = BR_Y;
			p[1] = t2; p[0] = a[3] + a[1]; p[2] = a[7] + a[5]; p[3] = a[2] - a[6];
		end else begin
			res.branch = BR_Z;
			p[2] = (t3 < 0) ? 0 : t3;
			p[0] = a[2] + a[6]; p[1] = a[7] + a[5]; p[3] = a[3] - a[1];
		end
		for (int i = 0; i < 4; i++) begin
			mag[i] = (p[i] < 0) ? -p[i] : p[i];
			sum += mag[i] * mag[i];
		end
		if (sum == 0) begin
			q[0] = 0; q[1] = 0; q[2] = 0; q[3] = clip(one);
		end else begin
			norm = int_sqrt(sum);
			for (int i = 0; i < 4; i++) begin
				r = ((mag[i] << FRAC_W) + (norm >> 1)) / norm;
				s = longint'(r);
				q[i] = clip(p[i] < 0 ? -s : s);
			end
		end
		res.x = q[0]; res.y = q[1]; res.z = q[2]; res.w = q[3];
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh4000;
			3: return -16'sh4000;
			4: return '0;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic matrix_t random_matrix();
		matrix_t m;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++)
			m.e[i] = (kind < 3) ? pick_value() : DATA_W'($urandom);
		if (kind >= 3 && kind < 7) begin
			// near-rotation shapes: scaled signed permutations
			for (int i = 0; i < 9; i++)
				m.e[i] = $signed(DATA_W'($urandom_range(0, 1200))) - 16'sd600;
			case ($urandom_range(0, 3))
				0: begin
					m.e[0] += 16'sd16000; m.e[4] += 16'sd16000; m.e[8] += 16'sd16000;
				end
				1: begin
					m.e[0] += 16'sd16000; m.e[4] -= 16'sd16000; m.e[8] -= 16'sd16000;
				end
				2: begin
					m.e[0] -= 16'sd16000; m.e[4] += 16'sd16000; m.e[8] -= 16'sd16000;
				end
				default: begin
					m.e[0] -= 16'sd16000; m.e[4] -= 16'sd16000; m.e[8] += 16'sd16000;
				end
			endcase
		end
		return m;
	endfunction

	function automatic matrix_t diag_matrix(int d0, int d1, int d2, int off);
		matrix_t m;
		for (int i = 0; i < 9; i++)
			m.e[i] = DATA_W'(off);
		m.e[0] = DATA_W'(d0); m.e[4] = DATA_W'(d1); m.e[8] = DATA_W'(d2);
		return m;
	endfunction

	task automatic drain();
		while (pending_items.size() != 0 || expected_quats.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic set_threshold(logic [THR_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		threshold = v;
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && start && !busy_at_edge && pending_items.size() != 0)
			void'(pending_items.pop_front());
		if (arst_n && pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
			start <= 1'b1;
			e00 <= pending_items[0].e[0]; e01 <= pending_items[0].e[1];
			e02 <= pending_items[0].e[2]; e10 <= pending_items[0].e[3];
			e11 <= pending_items[0].e[4]; e12 <= pending_items[0].e[5];
			e20 <= pending_items[0].e[6]; e21 <= pending_items[0].e[7];
			e22 <= pending_items[0].e[8];
		end else begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		quat_t want;
		matrix_t m;
		busy_at_edge <= busy;
		if (arst_n && start && !busy) begin
			m.e[0] = e00; m.e[1] = e01; m.e[2] = e02;
			m.e[3] = e10; m.e[4] = e11; m.e[5] = e12;
			m.e[6] = e20; m.e[7] = e21; m.e[8] = e22;
			expected_quats.push_back(shepperd(m, threshold));
		end
		if (arst_n && done) begin
			if (expected_quats.size() == 0) begin
				report_mismatch("unexpected quaternion", 0, 0);
			end else begin
				want = expected_quats.pop_front();
				if (quat_x !== want.x) report_mismatch("quat_x", quat_x, want.x);
				if (quat_y !== want.y) report_mismatch("quat_y", quat_y, want.y);
				if (quat_z !== want.z) report_mismatch("quat_z", quat_z, want.z);
				if (quat_w !== want.w) report_mismatch("quat_w", quat_w, want.w);
				if (branch_taken !== want.branch)
					report_mismatch("branch_taken", branch_taken, want.branch);
			end
		end
	end

	initial begin
		logic [THR_W-1:0] thr_list [5];
		start = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
		{e00, e01, e02, e10, e11, e12, e20, e21, e22} = '0;
		busy_at_edge = 1'b0;
		errors = 0;
		calm = 1'b0;
		threshold = 15'd1;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed: identity, each branch, extremes
		pending_items.push_back(diag_matrix(16384, 16384, 16384, 0));
		pending_items.push_back(diag_matrix(16384, -16384, -16384, 0));
		pending_items.push_back(diag_matrix(-16384, 16384, -16384, 0));
		pending_items.push_back(diag_matrix(-16384, -16384, 16384, 0));
		pending_items.push_back(diag_matrix(-16384, 0, 0, 0));
		pending_items.push_back(diag_matrix(0, -16384, -16384, 0));
		pending_items.push_back(diag_matrix(-32768, -32768, -32768, 0));
		pending_items.push_back(diag_matrix(32767, 32767, 32767, 32767));
		pending_items.push_back(diag_matrix(-32768, -32768, -32768, -32768));
		pending_items.push_back(diag_matrix(-32768, -32768, 32767, -32768));
		pending_items.push_back(diag_matrix(-5462, -5461, -5461, 0));
		pending_items.push_back(diag_matrix(0, 32767, -32768, 32767));
		drain();

		thr_list = '{15'd1, 15'd0, 15'h7fff, 15'd16384, 15'h2aaa};
		for (int ph = 0; ph < 5; ph++) begin
			set_threshold(thr_list[ph]);
			calm = (ph == 2);
			for (int n = 0; n < 140; n++)
				pending_items.push_back(random_matrix());
			drain();
		end

		if (errors == 0)
			$display("rotation_matrix_to_quaternion regression: pass");
		else
			$display("rotation_matrix_to_quaternion regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("rotation_matrix_to_quaternion regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_fifo.sv
hw/rtl/rmq_back.sv
hw/rtl/rotation_matrix_to_quaternion.sv
test/rotation_matrix_to_quaternion_test.sv
